// ===== rtl/core/hsv_to_rgb_converter_core_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shorthand for clocked assertions that are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSV2RGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSV2RGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths and the hue sector codes shared by the converter files.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W = 15;
  localparam int CH_W  = 9;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [CH_W-1:0]  chan_t;

  // 60-degree hue sectors, named after the color at the start of each one.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

endpackage

// ===== rtl/core/hsv2rgb_hsv_if.sv =====
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel that carries one hue, saturation, brightness request.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
  import hsv2rgb_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// ===== rtl/core/hsv2rgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel that carries one red, green, blue request.
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if;
  import hsv2rgb_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Six-stage pipeline that turns fixed-point hue, saturation, brightness into
// red, green, blue.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock unless a stall holds it and passes
// each result through the six register stages: hue split, reciprocal
// multiply for the sector fraction, quotient correction, saturation products,
// brightness products, and the channel select into the output register. Each
// stage holds its request only while the stage after it is full and stalled,
// so bubbles close up and the input keeps flowing while a result waits.
// Saturation and brightness above 1.0 are clamped, hue at or above 360 degrees
// counts as 0, and zero saturation yields grey through the same arithmetic.
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv_to_rgb_converter_core #(
  parameter int CHANNEL_FRAC_BITS = 8,
  parameter int HUE_FRAC_BITS     = 6
) (
  input logic           clk,
  input logic           rst,
  hsv2rgb_hsv_if.sink   hsv,
  hsv2rgb_rgb_if.source rgb
);
  import hsv2rgb_pkg::*;

  localparam int NS  = 6;
  localparam int CFB = CHANNEL_FRAC_BITS;
  localparam int CW  = CFB + 1;
  localparam int SW  = (CW > CH_W) ? CW : CH_W;
  localparam int HCW = (9 + HUE_FRAC_BITS > HUE_W) ? 9 + HUE_FRAC_BITS : HUE_W;
  localparam int RW  = 6 + HUE_FRAC_BITS;
  localparam int XW  = CFB + 4;
  localparam int MW  = CFB + 5;
  localparam int RECIP_SHIFT = CFB + 8;
  localparam int PW  = XW + MW;

  localparam logic [CW-1:0]  ONE_C = {1'b1, {CFB{1'b0}}};
  localparam logic [SW-1:0]  ONE_S = SW'(ONE_C);
  localparam logic [HCW-1:0] HUE_FULL = HCW'(360) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] THR1 = HCW'(60) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] THR2 = HCW'(120) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] THR3 = HCW'(180) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] THR4 = HCW'(240) << HUE_FRAC_BITS;
  localparam logic [HCW-1:0] THR5 = HCW'(300) << HUE_FRAC_BITS;
  localparam logic [MW-1:0]  RECIP = MW'((1 << RECIP_SHIFT) / 15);

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [NS-1:0] vld_in;

  // Pipeline control: a stage loads when it is empty or the next one loads.
  always_comb begin
    en[NS-1] = !vld[NS-1] || rgb.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in    = {vld[NS-2:0], hsv.valid};
  assign hsv.ready = en[0];
  assign rgb.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: clamp, hue wrap, sector split.
  logic [SW-1:0]  sat_ext;
  logic [SW-1:0]  bri_ext;
  logic [CW-1:0]  sat_cl;
  logic [CW-1:0]  bri_cl;
  logic [HCW-1:0] hue_ext;
  logic [HCW-1:0] hue_w;
  logic [HCW-1:0] base;
  logic [HCW-1:0] rem_full;
  logic [RW-1:0]  rem;
  logic [RW+CFB-1:0] rem_scaled;
  sector_t        sector_next;

  sector_t        s0_sector;
  logic [XW-1:0]  s0_x;
  logic [CW-1:0]  s0_sat;
  logic [CW-1:0]  s0_val;

  always_comb begin
    sat_ext = SW'(hsv.saturation);
    bri_ext = SW'(hsv.brightness);
    sat_cl  = (sat_ext > ONE_S) ? ONE_C : sat_ext[CW-1:0];
    bri_cl  = (bri_ext > ONE_S) ? ONE_C : bri_ext[CW-1:0];
    hue_ext = HCW'(hsv.hue);
    hue_w   = (hue_ext >= HUE_FULL) ? '0 : hue_ext;
    priority if (hue_w >= THR5) begin
      sector_next = SEC_MAGENTA;
      base        = THR5;
    end else if (hue_w >= THR4) begin
      sector_next = SEC_BLUE;
      base        = THR4;
    end else if (hue_w >= THR3) begin
      sector_next = SEC_CYAN;
      base        = THR3;
    end else if (hue_w >= THR2) begin
      sector_next = SEC_GREEN;
      base        = THR2;
    end else if (hue_w >= THR1) begin
      sector_next = SEC_YELLOW;
      base        = THR1;
    end else begin
      sector_next = SEC_RED;
      base        = '0;
    end
    rem_full   = hue_w - base;
    rem        = rem_full[RW-1:0];
    rem_scaled = {rem, {CFB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_sector <= sector_next;
      // A sector is 15 * 4 * 2^HUE_FRAC_BITS; dividing out the power of two
      // first leaves a plain divide by 15.
      s0_x      <= rem_scaled[RW+CFB-1:HUE_FRAC_BITS+2];
      s0_sat    <= sat_cl;
      s0_val    <= bri_cl;
    end
  end

  // Stage 1: reciprocal multiply, estimate is the quotient or one below.
  logic [PW-1:0] recip_prod;
  sector_t       s1_sector;
  logic [XW-1:0] s1_x;
  logic [CW-1:0] s1_quot;
  logic [CW-1:0] s1_sat;
  logic [CW-1:0] s1_val;
  logic [CW-1:0] s1_p;

  assign recip_prod = PW'(s0_x) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sector <= s0_sector;
      s1_x      <= s0_x;
      s1_quot   <= recip_prod[RECIP_SHIFT +: CW];
      s1_sat    <= s0_sat;
      s1_val    <= s0_val;
    end
  end

  hsv2rgb_scale #(.FRAC_BITS(CFB)) u_scale_p (
    .clk    (clk),
    .en     (en[1]),
    .val    (s0_val),
    .amount (s0_sat),
    .term   (s1_p)
  );

  // Stage 2: quotient correction gives the sector fraction.
  logic [XW:0]    quot15;
  logic [XW:0]    resid;
  logic           corr;
  sector_t        s2_sector;
  logic [CFB-1:0] s2_frac;
  logic [CW-1:0]  s2_sat;
  logic [CW-1:0]  s2_val;
  logic [CW-1:0]  s2_p;

  always_comb begin
    quot15 = {s1_quot, 4'b0000} - (XW+1)'(s1_quot);
    resid  = {1'b0, s1_x} - quot15;
    corr   = resid >= (XW+1)'(15);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sector <= s1_sector;
      s2_frac   <= CFB'(s1_quot + CW'(corr));
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;
      s2_p      <= s1_p;
    end
  end

  // Stage 3: saturation scaled by the fraction and by its complement.
  logic [CW+CFB-1:0] prod_a;
  logic [CW-1:0]     frac_c;
  logic [2*CW-1:0]   prod_b;
  sector_t           s3_sector;
  logic [CW-1:0]     s3_a;
  logic [CW-1:0]     s3_b;
  logic [CW-1:0]     s3_val;
  logic [CW-1:0]     s3_p;

  always_comb begin
    prod_a = (CW+CFB)'(s2_sat) * (CW+CFB)'(s2_frac);
    frac_c = ONE_C - CW'(s2_frac);
    prod_b = (2*CW)'(s2_sat) * (2*CW)'(frac_c);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sector <= s2_sector;
      s3_a      <= prod_a[CFB +: CW];
      s3_b      <= prod_b[CFB +: CW];
      s3_val    <= s2_val;
      s3_p      <= s2_p;
    end
  end

  // Stage 4: brightness products for q and t.
  sector_t       s4_sector;
  logic [CW-1:0] s4_val;
  logic [CW-1:0] s4_p;
  logic [CW-1:0] s4_q;
  logic [CW-1:0] s4_t;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sector <= s3_sector;
      s4_val    <= s3_val;
      s4_p      <= s3_p;
    end
  end

  hsv2rgb_scale #(.FRAC_BITS(CFB)) u_scale_q (
    .clk    (clk),
    .en     (en[4]),
    .val    (s3_val),
    .amount (s3_a),
    .term   (s4_q)
  );

  hsv2rgb_scale #(.FRAC_BITS(CFB)) u_scale_t (
    .clk    (clk),
    .en     (en[4]),
    .val    (s3_val),
    .amount (s3_b),
    .term   (s4_t)
  );

  // Stage 5: sector picks the source of each channel.
  logic [CW-1:0] red_sel;
  logic [CW-1:0] green_sel;
  logic [CW-1:0] blue_sel;
  chan_t         out_red;
  chan_t         out_green;
  chan_t         out_blue;

  always_comb begin
    unique case (s4_sector)
      SEC_RED: begin
        red_sel = s4_val; green_sel = s4_t; blue_sel = s4_p;
      end
      SEC_YELLOW: begin
        red_sel = s4_q; green_sel = s4_val; blue_sel = s4_p;
      end
      SEC_GREEN: begin
        red_sel = s4_p; green_sel = s4_val; blue_sel = s4_t;
      end
      SEC_CYAN: begin
        red_sel = s4_p; green_sel = s4_q; blue_sel = s4_val;
      end
      SEC_BLUE: begin
        red_sel = s4_t; green_sel = s4_p; blue_sel = s4_val;
      end
      default: begin
        red_sel = s4_val; green_sel = s4_p; blue_sel = s4_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_red   <= CH_W'(red_sel);
      out_green <= CH_W'(green_sel);
      out_blue  <= CH_W'(blue_sel);
    end
  end

  assign rgb.red   = out_red;
  assign rgb.green = out_green;
  assign rgb.blue  = out_blue;

  `HSV2RGB_ASSERT_NEXT(a_in_capture, hsv.valid && hsv.ready, vld[0],
    "accepted request did not enter the first stage")
  `HSV2RGB_ASSERT_NOW(a_quot_window, vld[1], resid < (XW+1)'(30),
    "reciprocal estimate is more than one below the quotient")
  `HSV2RGB_ASSERT_NOW(a_term_bound, vld[3], s3_a < ONE_C && s3_b <= ONE_C,
    "saturation term exceeds one")
  `HSV2RGB_ASSERT_NEXT(a_stall_hold, vld[4] && !en[4], vld[4],
    "stalled stage lost its request")
endmodule

// ===== rtl/core/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB term scaler
// Registered val * (1.0 - amount), truncated to the channel fixed-point format.
// ----------------------------------------------------------------------------
module hsv2rgb_scale #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               en,
  input  logic [FRAC_BITS:0] val,
  input  logic [FRAC_BITS:0] amount,
  output logic [FRAC_BITS:0] term
);
  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE_C = {1'b1, {FRAC_BITS{1'b0}}};

  logic [CW-1:0]   keep;
  logic [2*CW-1:0] prod;

  // amount never exceeds 1.0, so keep stays within 0..1.0.
  assign keep = ONE_C - amount;
  assign prod = (2*CW)'(val) * (2*CW)'(keep);

  always_ff @(posedge clk) begin
    if (en) begin
      term <= prod[FRAC_BITS +: CW];
    end
  end
endmodule

// ===== tb/hsv2rgb_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB pixel checker
// Watches both pixel channels, computes the RGB value due for every accepted
// HSV request, and compares each returned pixel with the oldest one due.
// ----------------------------------------------------------------------------
module hsv2rgb_pixel_checker #(
  parameter int CHANNEL_FRAC_BITS = 8,
  parameter int HUE_FRAC_BITS     = 6
) (
  input  logic   clk,
  input  logic   rst,
  hsv2rgb_hsv_if hsv,
  hsv2rgb_rgb_if rgb,
  output int     mismatch_count,
  output int     pending
);
  import hsv2rgb_pkg::*;

  localparam int unsigned ONE         = 1 << CHANNEL_FRAC_BITS;
  localparam int unsigned HUE_FULL    = 360 << HUE_FRAC_BITS;
  localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int          REPORT_MAX  = 10;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_pixel_t;

  rgb_pixel_t rgb_due_q[$];
  rgb_pixel_t want;

  // Brightness scaled by (1.0 - k), truncated.
  function automatic int unsigned fade(input int unsigned v, input int unsigned k);
    return (v * (ONE - k)) >> CHANNEL_FRAC_BITS;
  endfunction

  function automatic rgb_pixel_t expected_rgb(input hue_t h, input chan_t s, input chan_t v);
    int unsigned hh, ss, vv, rem, frac, p, q, t, r, g, b;
    sector_t     sec;
    rgb_pixel_t  px;
    hh = h;
    ss = (s > ONE) ? ONE : s;
    vv = (v > ONE) ? ONE : v;
    if (ss == 0) begin
      r = vv;
      g = vv;
      b = vv;
    end else begin
      if (hh >= HUE_FULL) begin
        hh = 0;
      end
      sec  = sector_t'(3'(hh / SECTOR_SPAN));
      rem  = hh % SECTOR_SPAN;
      frac = (rem << CHANNEL_FRAC_BITS) / SECTOR_SPAN;
      p    = fade(vv, ss);
      q    = fade(vv, (ss * frac) >> CHANNEL_FRAC_BITS);
      t    = fade(vv, (ss * (ONE - frac)) >> CHANNEL_FRAC_BITS);
      case (sec)
        SEC_RED: begin
          r = vv; g = t; b = p;
        end
        SEC_YELLOW: begin
          r = q; g = vv; b = p;
        end
        SEC_GREEN: begin
          r = p; g = vv; b = t;
        end
        SEC_CYAN: begin
          r = p; g = q; b = vv;
        end
        SEC_BLUE: begin
          r = t; g = p; b = vv;
        end
        default: begin
          r = vv; g = p; b = q;
        end
      endcase
    end
    px.red   = chan_t'(r);
    px.green = chan_t'(g);
    px.blue  = chan_t'(b);
    return px;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (hsv.valid && hsv.ready) begin
        rgb_due_q.push_back(expected_rgb(hsv.hue, hsv.saturation, hsv.brightness));
      end
      if (rgb.valid && rgb.ready) begin
        if (rgb_due_q.size() == 0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     rgb.red, rgb.green, rgb.blue);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = rgb_due_q.pop_front();
          if (rgb.red !== want.red || rgb.green !== want.green ||
              rgb.blue !== want.blue) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       rgb.red, rgb.green, rgb.blue);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending <= rgb_due_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed corner pixels and then random pixels through phases of
// sender gaps and receiver stalls, with one long output stall, and reports
// the verdict from the pixel checker.
// ----------------------------------------------------------------------------
module tb_top;
  import hsv2rgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 60;
  localparam int CHUNK_ITEMS    = 95;
  localparam int DRAIN_CYCLES   = 12;

  typedef enum logic [1:0] {
    PH_FLOW,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } traffic_phase_t;

  logic           clk;
  logic           rst;
  traffic_phase_t phase;
  logic           hold_request;
  int             idle_cycles;
  int             mismatch_count;
  int             pending;

  hsv2rgb_hsv_if hsv_ch ();
  hsv2rgb_rgb_if rgb_ch ();

  hsv_to_rgb_converter_core u_top (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  hsv2rgb_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .hsv            (hsv_ch),
    .rgb            (rgb_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #1 clk = ~clk;
    end
  end

  function automatic int send_idle_pct(input traffic_phase_t ph);
    case (ph)
      PH_SEND_IDLE: return 60;
      PH_BOTH:      return 17;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input traffic_phase_t ph);
    case (ph)
      PH_RECV_STALL: return 60;
      PH_BOTH:       return 17;
      default:       return 0;
    endcase
  endfunction

  // Offers one request and returns after the edge that accepts it.
  task automatic send_pixel(input hue_t h, input chan_t s, input chan_t v);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct(phase)) begin
      gap++;
    end
    repeat (gap) begin
      @(negedge clk);
      hsv_ch.valid      <= 1'b0;
      hsv_ch.hue        <= hue_t'($urandom);
      hsv_ch.saturation <= chan_t'($urandom);
      hsv_ch.brightness <= chan_t'($urandom);
    end
    @(negedge clk);
    hsv_ch.valid      <= 1'b1;
    hsv_ch.hue        <= h;
    hsv_ch.saturation <= s;
    hsv_ch.brightness <= v;
    do begin
      @(posedge clk);
    end while (!hsv_ch.ready);
  endtask

  task automatic send_random_pixel();
    hue_t  h;
    chan_t s;
    chan_t v;
    case ($urandom_range(9))
      0:       h = hue_t'($urandom_range(32767, 23040));
      1:       h = hue_t'(3840 * $urandom_range(5) + $urandom_range(1) * 3839);
      default: h = hue_t'($urandom_range(23039, 0));
    endcase
    case ($urandom_range(9))
      0:       s = '0;
      1:       s = chan_t'($urandom_range(511, 257));
      2:       s = chan_t'(256);
      default: s = chan_t'($urandom_range(255, 1));
    endcase
    case ($urandom_range(9))
      0:       v = chan_t'($urandom_range(511, 257));
      1:       v = chan_t'(256);
      2:       v = '0;
      default: v = chan_t'($urandom_range(255, 0));
    endcase
    send_pixel(h, s, v);
  endtask

  // Output side: random stalls per phase, plus one long hold when asked.
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left   = 0;
    hold_taken   = 1'b0;
    rgb_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        rgb_ch.ready <= 1'b0;
      end else begin
        rgb_ch.ready <= ($urandom_range(99) >= recv_stall_pct(phase));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    phase             = PH_FLOW;
    hold_request      = 1'b0;
    hsv_ch.valid      = 1'b0;
    hsv_ch.hue        = '0;
    hsv_ch.saturation = '0;
    hsv_ch.brightness = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sector starts, sector ends, out-of-range hue, grey and clamped inputs.
    send_pixel(hue_t'(0),     chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(3840),  chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(7680),  chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(11520), chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(15360), chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(19200), chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(3839),  chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(23039), chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(23040), chan_t'(256), chan_t'(256));
    send_pixel(hue_t'(32767), chan_t'(200), chan_t'(200));
    send_pixel(hue_t'(5000),  chan_t'(0),   chan_t'(123));
    send_pixel(hue_t'(32767), chan_t'(0),   chan_t'(511));
    send_pixel(hue_t'(1920),  chan_t'(511), chan_t'(256));
    send_pixel(hue_t'(9000),  chan_t'(128), chan_t'(511));
    send_pixel(hue_t'(0),     chan_t'(0),   chan_t'(0));
    send_pixel(hue_t'(12345), chan_t'(1),   chan_t'(1));
    send_pixel(hue_t'(17000), chan_t'(255), chan_t'(255));
    send_pixel(hue_t'(21000), chan_t'(256), chan_t'(0));
    send_pixel(hue_t'(2500),  chan_t'(300), chan_t'(300));
    send_pixel(hue_t'(6000),  chan_t'(100), chan_t'(256));
    send_pixel(hue_t'(0),     chan_t'(1),   chan_t'(256));
    send_pixel(hue_t'(14000), chan_t'(256), chan_t'(1));

    // The output holds off while requests keep coming, so the pipeline fills
    // up and has to stall its input.
    hold_request = 1'b1;
    repeat (40) send_random_pixel();

    for (int chunk = 0; chunk < 8; chunk++) begin
      phase = traffic_phase_t'(chunk % 4);
      repeat (CHUNK_ITEMS) send_random_pixel();
    end

    @(negedge clk);
    hsv_ch.valid <= 1'b0;
    phase = PH_FLOW;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
